[rtl/core/wstfu_pkg.sv]
// Shared types and constants for the WebSocket text frame unmasker.
package wstfu_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_DATA    = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   // Header checks
   localparam logic [7:0] FIN_BIT      = 8'h80;
   localparam logic [7:0] OPCODE_MASK  = 8'h0F;
   localparam logic [7:0] OPCODE_TEXT  = 8'h01;
   localparam logic [7:0] LENGTH_MASK  = 8'h7F;
   localparam logic [6:0] MAX_LENGTH   = 7'd125;

   // Byte positions within a buffer
   localparam logic [7:0] POS_HEADER   = 8'd0;
   localparam logic [7:0] POS_LENGTH   = 8'd1;
   localparam logic [7:0] POS_KEY_LAST = 8'd5;
   localparam logic [7:0] POS_PAYLOAD  = 8'd6;
   localparam logic [7:0] POS_LIMIT    = 8'd255;
   // Payload byte at pos is last when pos >= length + LAST_OFFSET
   localparam logic [7:0] LAST_OFFSET  = 8'd5;

   // Classified work item passed from front to back
   typedef struct packed {
      status_type kind;
      logic       is_last;
      logic [7:0] data;
      logic [7:0] key;
   } op_type;

   // Result as presented at the response side
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_last;
      status_type status;
   } rsp_type;

endpackage

[rtl/core/websocket_text_frame_unmasker.sv]
// Top level of the WebSocket text frame unmasker.
//
//   channel   direction  handshake         payload
//   req       in         req_push/req_full rx_byte, buffer_end
//   rsp       out        rsp_empty/rsp_pop payload_byte, is_last, status
//
// One byte per cycle sustained while the rsp side keeps popping. The front
// classifies an accepted request into the op queue; the back unmasks it into
// the result queue when that has room, and the result is then on the rsp ports.
// Reset clears buffer position, length, key and both queues.
// A stalled rsp side fills the result queue, then the op queue, and only then
// raises req_full; from then on every byte waits, even one that gives no result.
module websocket_text_frame_unmasker #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   input  logic       req_buffer_end,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_is_last,
   output logic [1:0] rsp_status
);
   import wstfu_pkg::*;

   logic    accept;
   logic    op_push, op_full, op_pop, op_empty;
   op_type  op_front, op_back;
   logic    res_push, res_full;
   rsp_type res_back, res_out;

   // Take a request whenever the op queue has room
   assign req_full = op_full;
   assign accept   = req_push && !op_full;

   // Parse header, collect key, classify each byte
   wstfu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .buffer_end (req_buffer_end),
      .op_push    (op_push),
      .op         (op_front)
   );

   // Decouple classification from unmasking
   wstfu_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_front),
      .full      (op_full),
      .pop       (op_pop),
      .pop_data  (op_back),
      .empty     (op_empty)
   );

   // Unmask and build the result
   wstfu_back u_back (
      .op_empty (op_empty),
      .op       (op_back),
      .op_pop   (op_pop),
      .rsp_full (res_full),
      .rsp_push (res_push),
      .rsp      (res_back)
   );

   // Hold finished results until the consumer pops them
   wstfu_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_back),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out),
      .empty     (rsp_empty)
   );

   assign rsp_payload_byte = res_out.payload_byte;
   assign rsp_is_last      = res_out.is_last;
   assign rsp_status       = res_out.status;

endmodule

[rtl/core/wstfu_fifo.sv]
// Small register queue with full/empty flags and simultaneous push and pop.
module wstfu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/wstfu_front.sv]
// Front end: tracks buffer position, parses header and key, classifies bytes.
module wstfu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        rx_byte,
   input  logic              buffer_end,
   output logic              op_push,
   output wstfu_pkg::op_type op
);
   import wstfu_pkg::*;

   logic [7:0]  pos_ff,  pos_in;
   logic [6:0]  len_ff,  len_in;
   logic [31:0] key_ff,  key_in;
   logic        skip_ff, skip_in;
   logic        emit, done, bad_header, last_byte;
   logic [1:0]  lane;

   // Key lane and payload index mod 4 share the same low bits (pos - 2)
   assign lane      = {~pos_ff[1], pos_ff[0]};
   assign last_byte = (pos_ff >= ({1'b0, len_ff} + LAST_OFFSET));
   assign bad_header = ((rx_byte & FIN_BIT) != FIN_BIT) ||
                       ((rx_byte & OPCODE_MASK) != OPCODE_TEXT);

   always_comb begin
      emit       = 1'b0;
      done       = 1'b0;
      len_in     = len_ff;
      key_in     = key_ff;
      op.kind    = STATUS_INVALID;
      op.is_last = 1'b1;
      op.data    = '0;
      op.key     = key_ff[8*lane +: 8];

      if (skip_ff) begin
         emit = 1'b0;
      end else if (pos_ff == POS_HEADER) begin
         if (bad_header) begin
            emit = 1'b1;
            done = 1'b1;
         end else if (buffer_end) begin
            emit = 1'b1;
         end
      end else if (pos_ff == POS_LENGTH) begin
         len_in = 7'(rx_byte & LENGTH_MASK);
         if (len_in > MAX_LENGTH || buffer_end) begin
            emit = 1'b1;
            done = 1'b1;
         end
      end else if (pos_ff < POS_PAYLOAD) begin
         key_in[8*lane +: 8] = rx_byte;
         if (pos_ff == POS_KEY_LAST && len_ff == '0) begin
            emit    = 1'b1;
            done    = 1'b1;
            op.kind = STATUS_EMPTY;
         end else if (buffer_end) begin
            emit = 1'b1;
            done = 1'b1;
         end
      end else begin
         emit = 1'b1;
         if (last_byte) begin
            done    = 1'b1;
            op.kind = STATUS_DATA;
            op.data = rx_byte;
         end else if (buffer_end) begin
            done = 1'b1;
         end else begin
            op.kind    = STATUS_DATA;
            op.is_last = 1'b0;
            op.data    = rx_byte;
         end
      end

      // Position bookkeeping; a buffer end always restarts at the header
      pos_in  = pos_ff;
      skip_in = skip_ff;
      if (buffer_end) begin
         pos_in  = '0;
         skip_in = 1'b0;
      end else begin
         skip_in = skip_ff || done;
         if (!skip_in && pos_ff != POS_LIMIT) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   assign op_push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         len_ff  <= '0;
         key_ff  <= '0;
         skip_ff <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         key_ff  <= key_in;
         skip_ff <= skip_in;
      end
   end

endmodule

[rtl/core/wstfu_back.sv]
// Back end: unmasks payload bytes and forms the result.
module wstfu_back (
   input  logic               op_empty,
   input  wstfu_pkg::op_type  op,
   output logic               op_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output wstfu_pkg::rsp_type rsp
);
   import wstfu_pkg::*;

   assign op_pop   = !op_empty && !rsp_full;
   assign rsp_push = op_pop;

   always_comb begin
      rsp.status       = op.kind;
      rsp.is_last      = op.is_last;
      rsp.payload_byte = (op.kind == STATUS_DATA) ? (op.data ^ op.key) : '0;
   end

endmodule
